// File: sv/pcg_pkg.sv
// Shared types, constants and the microcode table of the PCG32 generator.
package pcg_pkg;

    localparam logic [63:0] LCG_MULT        = 64'h5851_F42D_4C95_7F2D;
    localparam logic [31:0] AUTO_STREAM_XOR = 32'hDEAD_BEEF;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // Program addresses.
    localparam pc_t PC_IDLE     = 4'd0;
    localparam pc_t PC_SEED     = 4'd1;
    localparam pc_t PC_WARM_L1  = 4'd2;
    localparam pc_t PC_WARM_L2  = 4'd3;
    localparam pc_t PC_WARM_L3  = 4'd4;
    localparam pc_t PC_WARM_L4  = 4'd5;
    localparam pc_t PC_ADD_SEED = 4'd6;
    localparam pc_t PC_MIX_L1   = 4'd7;
    localparam pc_t PC_MIX_L2   = 4'd8;
    localparam pc_t PC_MIX_L3   = 4'd9;
    localparam pc_t PC_MIX_L4   = 4'd10;
    localparam pc_t PC_DRAW     = 4'd11;
    localparam pc_t PC_DRAW_L2  = 4'd12;
    localparam pc_t PC_DRAW_L3  = 4'd13;
    localparam pc_t PC_DRAW_L4  = 4'd14;

    // The warm-up loop runs the LCG step three times.
    localparam logic [1:0] WARM_LAST = 2'd2;

    typedef enum logic [1:0] {
        MS_LL,
        MS_HL,
        MS_LH
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_INC,
        ACC_ADD_LO,
        ACC_ADD_HI
    } acc_op_t;

    typedef enum logic [1:0] {
        ST_HOLD,
        ST_INIT,
        ST_ADD_SEED,
        ST_LCG
    } st_op_t;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_LOOP,
        SQ_BRANCH_DRAW,
        SQ_FINISH
    } seq_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     prod_en;
        acc_op_t  acc_op;
        st_op_t   st_op;
        logic     emit;
        logic     set_seeded;
        seq_op_t  seq;
        pc_t      target;
    } ctrl_word_t;

    typedef struct packed {
        logic out_full;
        logic item_draw;
    } dp_status_t;

    localparam ctrl_word_t CTRL_NOP = '{
        mul_sel:    MS_LL,
        prod_en:    1'b0,
        acc_op:     ACC_HOLD,
        st_op:      ST_HOLD,
        emit:       1'b0,
        set_seeded: 1'b0,
        seq:        SQ_FINISH,
        target:     PC_IDLE
    };

    // One LCG step is four words: three partial products on the shared
    // 32x32 multiplier, accumulated onto the increment, then the state write.
    function automatic ctrl_word_t ucode_word(input pc_t pc);
        ctrl_word_t w;
        w = CTRL_NOP;
        w.seq = SQ_NEXT;
        unique case (pc) inside
            PC_SEED:
            begin
                w.st_op      = ST_INIT;
                w.set_seeded = 1'b1;
            end
            PC_WARM_L1, PC_MIX_L1, PC_DRAW:
            begin
                w.mul_sel = MS_LL;
                w.prod_en = 1'b1;
                w.acc_op  = ACC_INC;
            end
            PC_WARM_L2, PC_MIX_L2, PC_DRAW_L2:
            begin
                w.mul_sel = MS_HL;
                w.prod_en = 1'b1;
                w.acc_op  = ACC_ADD_LO;
            end
            PC_WARM_L3, PC_MIX_L3, PC_DRAW_L3:
            begin
                w.mul_sel = MS_LH;
                w.prod_en = 1'b1;
                w.acc_op  = ACC_ADD_HI;
            end
            PC_WARM_L4:
            begin
                w.st_op  = ST_LCG;
                w.seq    = SQ_LOOP;
                w.target = PC_WARM_L1;
            end
            PC_ADD_SEED:
            begin
                w.st_op = ST_ADD_SEED;
            end
            PC_MIX_L4:
            begin
                w.st_op  = ST_LCG;
                w.seq    = SQ_BRANCH_DRAW;
                w.target = PC_DRAW;
            end
            PC_DRAW_L4:
            begin
                w.st_op = ST_LCG;
                w.emit  = 1'b1;
                w.seq   = SQ_FINISH;
            end
            default:
            begin
                w = CTRL_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

// File: sv/pcg32_random_generator.sv
// Top level of the PCG32 XSH-RR random number generator.
//
// Input channel (in_valid/in_stall) carries one item per beat: action 0 draws
// a word, action 1 reseeds from the seed_value and stream_id registers. A draw
// gives one beat on the output channel (out_valid/out_stall); a reseed gives
// none. A draw that finds the generator unseeded first seeds it from entropy.
// A seeded draw runs the three partial products of the 64-bit LCG step on
// one shared 32x32 multiplier plus the state write; its word is registered
// onto random_word with out_valid in the draw's last step, and the next item
// is accepted in the draw's last step. A reseed runs the seed step, three
// warm-up LCG steps, the seed add and one more step; an unseeded draw runs
// these followed by a draw.
// The output register holds a finished word while out_stall is high; a new
// item is still accepted, and only the next draw's last step waits for it.
// Reset clears the registers, the sequencer and the seeded flag; the LCG
// state is always rebuilt by seeding before any draw. Configuration is an
// APB port with 64-bit data: seed_value at address 0, stream_id at 8.
module pcg32_random_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] entropy,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_word
);

    logic [63:0]         seed_value;
    logic [62:0]         stream_id;
    logic                accept;
    pcg_pkg::ctrl_word_t ctrl;
    pcg_pkg::dp_status_t status;

    pcg_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .seed_value (seed_value),
        .stream_id  (stream_id)
    );

    // The sequencer steps through the microcode table and issues one control word
    // per cycle to the datapath, a no-op while the last draw step waits on a full output register.
    pcg_ucode u_ucode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .status   (status),
        .accept   (accept),
        .ctrl     (ctrl)
    );

    pcg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .accept      (accept),
        .action      (action),
        .entropy     (entropy),
        .seed_value  (seed_value),
        .stream_id   (stream_id),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

endmodule

// File: sv/pcg_regs.sv
// APB configuration registers: seed value and stream selector.
module pcg_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [63:0] seed_value,
    output logic [62:0] stream_id
);

    logic [63:0] seed_reg;
    logic [62:0] stream_reg;
    logic        wr_en;

    // Only bit 3 selects a register; the byte offset bits are not decoded.
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            stream_reg <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[3])
            begin
                stream_reg <= pwdata[62:0];
            end
            else
            begin
                seed_reg <= pwdata;
            end
        end
    end

    assign prdata     = paddr[3] ? {1'b0, stream_reg} : seed_reg;
    assign seed_value = seed_reg;
    assign stream_id  = stream_reg;

endmodule

// File: sv/pcg_ucode.sv
// Microcode sequencer: program counter, loop counter and seeded flag.
module pcg_ucode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  pcg_pkg::dp_status_t status,
    output logic                accept,
    output pcg_pkg::ctrl_word_t ctrl
);

    pcg_pkg::pc_t       pc_reg, pc_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               seeded_reg, seeded_next;
    pcg_pkg::ctrl_word_t word;
    pcg_pkg::pc_t       entry;
    logic               hold;
    logic               done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= pcg_pkg::PC_IDLE;
            cnt_reg    <= '0;
            seeded_reg <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            cnt_reg    <= cnt_next;
            seeded_reg <= seeded_next;
        end
    end

    always_comb
    begin
        word = pcg_pkg::ucode_word(pc_reg);
        // The final draw step waits while the output register is still full.
        hold = word.emit && status.out_full;
        done = 1'b0;
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        if (!hold)
        begin
            unique case (word.seq)
                pcg_pkg::SQ_NEXT:
                begin
                    pc_next = pc_reg + pcg_pkg::pc_t'(1);
                end
                pcg_pkg::SQ_LOOP:
                begin
                    if (cnt_reg == pcg_pkg::WARM_LAST)
                    begin
                        cnt_next = '0;
                        pc_next  = pc_reg + pcg_pkg::pc_t'(1);
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        pc_next  = word.target;
                    end
                end
                pcg_pkg::SQ_BRANCH_DRAW:
                begin
                    if (status.item_draw)
                    begin
                        pc_next = word.target;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                pcg_pkg::SQ_FINISH:
                begin
                    done = 1'b1;
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end

        in_stall = !done;
        accept   = done && in_valid;
        seeded_next = seeded_reg || (word.set_seeded && !hold);

        if (action || !seeded_next)
        begin
            entry = pcg_pkg::PC_SEED;
        end
        else
        begin
            entry = pcg_pkg::PC_DRAW;
        end

        if (done)
        begin
            pc_next = accept ? entry : pcg_pkg::PC_IDLE;
        end

        ctrl = hold ? pcg_pkg::CTRL_NOP : word;
    end

endmodule

// File: sv/pcg_datapath.sv
// Datapath: shared 32x32 multiplier, accumulator, LCG state and output register.
module pcg_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  pcg_pkg::ctrl_word_t ctrl,
    input  logic                accept,
    input  logic                action,
    input  logic [31:0]         entropy,
    input  logic [63:0]         seed_value,
    input  logic [62:0]         stream_id,
    output pcg_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         random_word
);

    logic [63:0] state_reg, state_next;
    logic [63:0] inc_reg, inc_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg;
    logic        act_reg;
    logic [31:0] entropy_reg;
    logic        out_valid_reg;
    logic [31:0] word_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] seed_src;
    logic [62:0] stream_src;

    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] x;
        logic [31:0] mixed;
        logic [63:0] twice;
        x     = s ^ (s >> 18);
        mixed = x[58:27];
        twice = {mixed, mixed} >> s[63:59];
        return twice[31:0];
    endfunction

    always_comb
    begin
        case (ctrl.mul_sel)
            pcg_pkg::MS_HL:
            begin
                mul_a = state_reg[63:32];
                mul_b = pcg_pkg::LCG_MULT[31:0];
            end
            pcg_pkg::MS_LH:
            begin
                mul_a = state_reg[31:0];
                mul_b = pcg_pkg::LCG_MULT[63:32];
            end
            default:
            begin
                mul_a = state_reg[31:0];
                mul_b = pcg_pkg::LCG_MULT[31:0];
            end
        endcase

        // A reseed item takes the registers, an unseeded draw its own entropy.
        seed_src   = act_reg ? seed_value : {32'd0, entropy_reg};
        stream_src = act_reg ? stream_id
                             : {31'd0, entropy_reg ^ pcg_pkg::AUTO_STREAM_XOR};

        case (ctrl.acc_op)
            pcg_pkg::ACC_INC:    acc_next = inc_reg;
            pcg_pkg::ACC_ADD_LO: acc_next = acc_reg + prod_reg;
            pcg_pkg::ACC_ADD_HI: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            default:             acc_next = acc_reg;
        endcase

        inc_next = inc_reg;
        case (ctrl.st_op)
            pcg_pkg::ST_INIT:
            begin
                state_next = '0;
                inc_next   = {stream_src, 1'b1};
            end
            pcg_pkg::ST_ADD_SEED: state_next = state_reg + seed_src;
            pcg_pkg::ST_LCG:      state_next = acc_reg + {prod_reg[31:0], 32'd0};
            default:              state_next = state_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        inc_reg   <= inc_next;
        acc_reg   <= acc_next;
        if (ctrl.prod_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (accept)
        begin
            act_reg     <= action;
            entropy_reg <= entropy;
        end
        if (ctrl.emit)
        begin
            word_reg <= xsh_rr(state_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_full  = out_valid_reg && out_stall;
    assign status.item_draw = !act_reg;
    assign out_valid        = out_valid_reg;
    assign random_word      = word_reg;

endmodule
